/* sv/euler_trs_model_matrix_defines.svh */
// Assertion macros for the Euler-angle model matrix block.
// Included by the top level; needs clk_i and rst_ni in the including scope.
`ifndef EULER_TRS_MODEL_MATRIX_DEFINES_SVH
`define EULER_TRS_MODEL_MATRIX_DEFINES_SVH
`ifndef SYNTHESIS
`define ETM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ETM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ETM_ASSERT_IMP(lbl, ante, cons, msg)
`define ETM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/etm_pkg.sv */
// Shared types and constants of the Euler-angle model matrix block.
// No dependencies; used by the CORDIC, matrix and top-level modules.
package etm_pkg;

  localparam int CORDIC_STEPS = 20;
  // Input register, one register per rotation step and one output register.
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Cosine and sine of one angle, Q.16, range -65536 to 65536.
  typedef struct packed {
    logic signed [17:0] cs;
    logic signed [17:0] sn;
  } trig_t;

  // Scale and position that travel alongside the CORDIC pipeline.
  typedef struct packed {
    logic [2:0][15:0]        scl;
    logic [2:0][31:0]        pos;
  } side_t;

  // Arctangent of 2^-i in binary-angle units, 2^32 per turn.
  function automatic logic signed [32:0] atan_turn(input int i);
    logic signed [32:0] a;
    case (i)
      0:  a = 33'sd536870912;
      1:  a = 33'sd316933406;
      2:  a = 33'sd167458907;
      3:  a = 33'sd85004756;
      4:  a = 33'sd42667331;
      5:  a = 33'sd21354465;
      6:  a = 33'sd10679838;
      7:  a = 33'sd5340245;
      8:  a = 33'sd2670163;
      9:  a = 33'sd1335087;
      10: a = 33'sd667544;
      11: a = 33'sd333772;
      12: a = 33'sd166886;
      13: a = 33'sd83443;
      14: a = 33'sd41722;
      15: a = 33'sd20861;
      16: a = 33'sd10430;
      17: a = 33'sd5215;
      18: a = 33'sd2608;
      19: a = 33'sd1304;
      default: a = 33'sd0;
    endcase
    return a;
  endfunction

endpackage

/* sv/etm_cordic.sv */
// Pipelined CORDIC giving cosine and sine of a 16-bit binary angle.
// Depends on etm_pkg; one rotation step per register stage.
module etm_cordic (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [15:0]       angle_i,
  output logic              valid_o,
  output etm_pkg::trig_t    trig_o
);
  import etm_pkg::*;

  logic                     vld_q [0:CORDIC_STEPS];
  logic                     flip_q [0:CORDIC_STEPS];
  logic signed [33:0]       x_q [0:CORDIC_STEPS];
  logic signed [33:0]       y_q [0:CORDIC_STEPS];
  logic signed [32:0]       z_q [0:CORDIC_STEPS];
  logic                     flip_d;
  logic [31:0]              u_d;
  logic                     out_vld_q;
  trig_t                    out_q;
  trig_t                    out_d;
  logic signed [33:0]       xr, yr;
  logic signed [17:0]       xc, yc;

  // Fold the second and third quadrants by a half turn.
  assign flip_d = angle_i[15] ^ angle_i[14];
  assign u_d    = {angle_i[15] ^ flip_d, angle_i[14:0], 16'h0000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    flip_q[0] <= flip_d;
    x_q[0]    <= CORDIC_GAIN;
    y_q[0]    <= 34'sd0;
    z_q[0]    <= $signed({u_d[31], u_d});
  end

  // One rotation step per stage.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [32:0] At = atan_turn(i);
    logic signed [33:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      flip_q[i+1] <= flip_q[i];
      if (!z_q[i][32]) begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        z_q[i+1] <= z_q[i] - At;
      end else begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        z_q[i+1] <= z_q[i] + At;
      end
    end
  end

  // Round to Q.16, clamp to one and undo the half-turn fold.
  always_comb begin
    xr = (x_q[CORDIC_STEPS] + 34'sd8192) >>> 14;
    yr = (y_q[CORDIC_STEPS] + 34'sd8192) >>> 14;
    if (xr > 34'sd65536)       xc = 18'sd65536;
    else if (xr < -34'sd65536) xc = -18'sd65536;
    else                       xc = xr[17:0];
    if (yr > 34'sd65536)       yc = 18'sd65536;
    else if (yr < -34'sd65536) yc = -18'sd65536;
    else                       yc = yr[17:0];
    out_d.cs = flip_q[CORDIC_STEPS] ? -xc : xc;
    out_d.sn = flip_q[CORDIC_STEPS] ? -yc : yc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign valid_o = out_vld_q;
  assign trig_o  = out_q;

endmodule

/* sv/etm_matrix.sv */
// Five-stage pipeline forming the scaled rotation entries from the sines and cosines.
// Depends on etm_pkg for the trig_t and side_t types.
module etm_matrix (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  etm_pkg::trig_t      tx_i,
  input  etm_pkg::trig_t      ty_i,
  input  etm_pkg::trig_t      tz_i,
  input  etm_pkg::side_t      side_i,
  output logic                valid_o,
  output logic signed [24:0]  ent_o [0:8],
  output logic [2:0][31:0]    pos_o
);
  import etm_pkg::*;

  logic [4:0]          vld_q;
  side_t               side_q [0:4];

  // Stage A: pairwise products.
  logic signed [35:0]  cycz_q, cysz_q, cxsz_q, cxcz_q, sxsy_q;
  logic signed [35:0]  sxcy_q, sxsz_q, cxsy_q, sxcz_q, cxcy_q;
  logic signed [17:0]  sya_q, cza_q, sza_q;
  // Stage B: triple products, pairs carried on.
  logic signed [53:0]  sxsycz_q, sxsysz_q, cxsycz_q, cxsysz_q;
  logic signed [35:0]  cyczb_q, cyszb_q, cxszb_q, cxczb_q;
  logic signed [35:0]  sxcyb_q, sxszb_q, sxczb_q, cxcyb_q;
  logic signed [17:0]  syb_q;
  // Stage C: Q.48 entries rounded to Q.24.
  logic signed [51:0]  r48 [0:8];
  logic signed [27:0]  r24_q [0:8];
  // Stage D: product with the scale.
  logic signed [44:0]  p_q [0:8];
  // Stage E: rounded and saturated entries.
  logic signed [24:0]  ent_q [0:8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 5'b0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // Side data moves in step with the valid bits.
  always_ff @(posedge clk_i) begin
    side_q[0] <= side_i;
    for (int s = 1; s < 5; s++) side_q[s] <= side_q[s-1];
  end

  always_ff @(posedge clk_i) begin
    cycz_q <= ty_i.cs * tz_i.cs;
    cysz_q <= ty_i.cs * tz_i.sn;
    cxsz_q <= tx_i.cs * tz_i.sn;
    cxcz_q <= tx_i.cs * tz_i.cs;
    sxsy_q <= tx_i.sn * ty_i.sn;
    sxcy_q <= tx_i.sn * ty_i.cs;
    sxsz_q <= tx_i.sn * tz_i.sn;
    cxsy_q <= tx_i.cs * ty_i.sn;
    sxcz_q <= tx_i.sn * tz_i.cs;
    cxcy_q <= tx_i.cs * ty_i.cs;
    sya_q  <= ty_i.sn;
    cza_q  <= tz_i.cs;
    sza_q  <= tz_i.sn;
  end

  always_ff @(posedge clk_i) begin
    sxsycz_q <= sxsy_q * cza_q;
    sxsysz_q <= sxsy_q * sza_q;
    cxsycz_q <= cxsy_q * cza_q;
    cxsysz_q <= cxsy_q * sza_q;
    cyczb_q  <= cycz_q;
    cyszb_q  <= cysz_q;
    cxszb_q  <= cxsz_q;
    cxczb_q  <= cxcz_q;
    sxcyb_q  <= sxcy_q;
    sxszb_q  <= sxsz_q;
    sxczb_q  <= sxcz_q;
    cxcyb_q  <= cxcy_q;
    syb_q    <= sya_q;
  end

  // Entries of X*Y*Z in Q.48, row-major order.
  always_comb begin
    r48[0] = 52'(cyczb_q) <<< 16;
    r48[1] = 52'(cyszb_q) <<< 16;
    r48[2] = 52'(syb_q) <<< 32;
    r48[3] = -(52'(cxszb_q) <<< 16) - 52'(sxsycz_q);
    r48[4] = (52'(cxczb_q) <<< 16) - 52'(sxsysz_q);
    r48[5] = 52'(sxcyb_q) <<< 16;
    r48[6] = (52'(sxszb_q) <<< 16) - 52'(cxsycz_q);
    r48[7] = -(52'(sxczb_q) <<< 16) - 52'(cxsysz_q);
    r48[8] = 52'(cxcyb_q) <<< 16;
  end

  for (genvar k = 0; k < 9; k++) begin : g_ent
    logic signed [51:0] r24w;
    logic signed [44:0] qw;
    assign r24w = (r48[k] + 52'sd8388608) >>> 24;
    assign qw   = (p_q[k] + 45'sd32768) >>> 16;

    always_ff @(posedge clk_i) begin
      r24_q[k] <= r24w[27:0];
      p_q[k]   <= r24_q[k] * $signed({1'b0, side_q[2].scl[k % 3]});
      if (qw > 45'sd16777215)       ent_q[k] <= 25'sd16777215;
      else if (qw < -45'sd16777216) ent_q[k] <= -25'sd16777216;
      else                          ent_q[k] <= qw[24:0];
    end

    assign ent_o[k] = ent_q[k];
  end

  assign valid_o = vld_q[4];
  assign pos_o   = side_q[4].pos;

endmodule

/* sv/euler_trs_model_matrix.sv */
// Top level of the Euler-angle translate-rotate-scale model matrix block.
// Depends on etm_pkg, etm_cordic, etm_matrix and the assertion macro header.
//
//   channel   handshake          payload
//   input     start_i / busy_o   angle_*_i, scale_*_i, pos_*_i
//   result    done_o (strobe)    rowR_colC_o, R in 0..2, C in 0..3
//
// One item may be started in every cycle; its result passes first through the
// three CORDIC lanes (one rotation step a stage) and then the matrix pipeline.
// busy_o stays low: the pipeline never halts.
// Reset clears only the valid bits; data registers carry no reset.
`include "euler_trs_model_matrix_defines.svh"
module euler_trs_model_matrix (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [15:0]         angle_x_i,
  input  logic [15:0]         angle_y_i,
  input  logic [15:0]         angle_z_i,
  input  logic [15:0]         scale_x_i,
  input  logic [15:0]         scale_y_i,
  input  logic [15:0]         scale_z_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  output logic                done_o,
  output logic signed [24:0]  row0_col0_o,
  output logic signed [24:0]  row0_col1_o,
  output logic signed [24:0]  row0_col2_o,
  output logic signed [31:0]  row0_col3_o,
  output logic signed [24:0]  row1_col0_o,
  output logic signed [24:0]  row1_col1_o,
  output logic signed [24:0]  row1_col2_o,
  output logic signed [31:0]  row1_col3_o,
  output logic signed [24:0]  row2_col0_o,
  output logic signed [24:0]  row2_col1_o,
  output logic signed [24:0]  row2_col2_o,
  output logic signed [31:0]  row2_col3_o
);
  import etm_pkg::*;

  logic                accept;
  logic                vx, vy, vz;
  trig_t               tx, ty, tz;
  side_t               side_d;
  side_t               side_q [0:CORDIC_LAT-1];
  logic [CORDIC_LAT-1:0] side_vld_q;
  logic signed [24:0]  ent [0:8];
  logic [2:0][31:0]    pos;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Three CORDIC lanes, one per angle.
  etm_cordic u_cordic_x (
    .clk_i, .rst_ni, .valid_i(accept), .angle_i(angle_x_i), .valid_o(vx), .trig_o(tx)
  );
  etm_cordic u_cordic_y (
    .clk_i, .rst_ni, .valid_i(accept), .angle_i(angle_y_i), .valid_o(vy), .trig_o(ty)
  );
  etm_cordic u_cordic_z (
    .clk_i, .rst_ni, .valid_i(accept), .angle_i(angle_z_i), .valid_o(vz), .trig_o(tz)
  );

  // Scale and position wait alongside the CORDIC lanes.
  assign side_d.scl = {scale_z_i, scale_y_i, scale_x_i};
  assign side_d.pos = {pos_z_i, pos_y_i, pos_x_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_vld_q <= '0;
    end else begin
      side_vld_q <= {side_vld_q[CORDIC_LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int s = 1; s < CORDIC_LAT; s++) side_q[s] <= side_q[s-1];
  end

  etm_matrix u_matrix (
    .clk_i,
    .rst_ni,
    .valid_i (vx & vy & vz),
    .tx_i    (tx),
    .ty_i    (ty),
    .tz_i    (tz),
    .side_i  (side_q[CORDIC_LAT-1]),
    .valid_o (done_o),
    .ent_o   (ent),
    .pos_o   (pos)
  );

  assign row0_col0_o = ent[0];
  assign row0_col1_o = ent[1];
  assign row0_col2_o = ent[2];
  assign row1_col0_o = ent[3];
  assign row1_col1_o = ent[4];
  assign row1_col2_o = ent[5];
  assign row2_col0_o = ent[6];
  assign row2_col1_o = ent[7];
  assign row2_col2_o = ent[8];
  assign row0_col3_o = $signed(pos[0]);
  assign row1_col3_o = $signed(pos[1]);
  assign row2_col3_o = $signed(pos[2]);

  // The side line must stay aligned with the CORDIC lanes.
  `ETM_ASSERT_NXT(a_side_enter, accept, side_vld_q[0], "side line missed an accepted beat")
  `ETM_ASSERT_IMP(a_lane_align, vx, side_vld_q[CORDIC_LAT-1] && vy && vz,
                  "CORDIC lanes and side line out of step")
  `ETM_ASSERT_IMP(a_side_align, side_vld_q[CORDIC_LAT-1], vx,
                  "side beat without CORDIC result")

endmodule
